// ===== rtl/blsc_pkg.sv =====
// ----------------------------------------------------------------------------
// blsc_pkg: shared definitions for the balanced literal scanner
// Sizes, character codes, byte classes, lexer modes and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package blsc_pkg;

	// stack of expected closers and length limit
	localparam int STACK_DEPTH = 64;
	localparam int MAX_LENGTH  = 65535;
	localparam int LEN_CAP     = (MAX_LENGTH < 65535) ? MAX_LENGTH : 65535;
	localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int POS_W       = 16;
	localparam int LEN_W       = 16;

	// token queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// character codes
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_BQUOTE  = 8'h60;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// byte classes produced by the front
	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_DQUOTE,
		CLS_SQUOTE,
		CLS_BQUOTE,
		CLS_SLASH,
		CLS_STAR,
		CLS_BSLASH,
		CLS_NEWLINE,
		CLS_LBRACE,
		CLS_LBRACK,
		CLS_RBRACE,
		CLS_RBRACK
	} byte_class_t;

	typedef struct packed {
		byte_class_t cls;
		logic        eot;
	} token_t;

	// lexer modes
	typedef enum logic [3:0] {
		MODE_CODE       = 4'd0,
		MODE_SLASH      = 4'd1,
		MODE_DQ         = 4'd2,
		MODE_DQ_ESC     = 4'd3,
		MODE_SQ         = 4'd4,
		MODE_SQ_ESC     = 4'd5,
		MODE_BQ         = 4'd6,
		MODE_BQ_ESC     = 4'd7,
		MODE_LINE       = 4'd8,
		MODE_BLOCK      = 4'd9,
		MODE_BLOCK_STAR = 4'd10
	} lex_mode_t;

	// result codes
	typedef enum logic [1:0] {
		ST_BALANCED = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_OPEN     = 2'd2,
		ST_LIMIT    = 2'd3
	} scan_status_t;

endpackage

`default_nettype wire

// ===== rtl/balanced_literal_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// balanced_literal_scanner_unit: bracket matching scanner for literals
// Finds the end of an object or array literal while skipping strings and
// comments, and reports its length or the reason the scan failed.
// ----------------------------------------------------------------------------
// Usage:
//   Text bytes enter on text_byte/end_of_text with text_valid/text_ready,
//   one transfer per byte, starting at the literal's opening bracket.
//   end_of_text marks the last byte of a text; every text gives exactly
//   one result on scan_status/literal_length with result_valid/result_ready.
//   Throughput is one byte per cycle while no result waits on a stalled receiver.
//   A transferred byte is classified into a two-entry token queue; the
//   lexer takes it from the queue head and loads any result into the
//   output register, which drives result_valid.
//   The lexer mode machine and the one-pop-per-cycle closer stack (top two
//   entries in registers, a registered read from stack memory for the rest)
//   set this rate.
//   When the receiver stalls, the result waits in the output register; the
//   queue still takes bytes until it is full, and text_ready then drops.
//   After a result, bytes up to end_of_text are consumed without effect.
//   Reset clears the lexer state, queue and output register at once; no
//   clearing pass is needed and the first byte can follow right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module balanced_literal_scanner_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_text,
	input  wire logic        text_valid,
	output logic             text_ready,
	output logic [1:0]       scan_status,
	output logic [15:0]      literal_length,
	output logic             result_valid,
	input  wire logic        result_ready
);
	import blsc_pkg::*;

	logic   queue_full;
	logic   queue_push;
	logic   queue_pop;
	logic   queue_empty;
	token_t push_tok;
	token_t head_tok;

	// byte intake
	blsc_front u_front (
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.queue_full  (queue_full),
		.queue_push  (queue_push),
		.queue_tok   (push_tok)
	);

	// token queue
	blsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (queue_push),
		.push_tok (push_tok),
		.full     (queue_full),
		.pop      (queue_pop),
		.head_tok (head_tok),
		.empty    (queue_empty)
	);

	// lexer, stack and result register
	blsc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok            (head_tok),
		.tok_avail      (~queue_empty),
		.tok_take       (queue_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.scan_status    (scan_status),
		.literal_length (literal_length)
	);

endmodule

`default_nettype wire

// ===== rtl/blsc_front.sv =====
// ----------------------------------------------------------------------------
// blsc_front: byte intake and classification
// Accepts text bytes and turns each into a byte class token for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module blsc_front (
	input  wire logic            [7:0] text_byte,
	input  wire logic                  end_of_text,
	input  wire logic                  text_valid,
	output logic                       text_ready,
	input  wire logic                  queue_full,
	output logic                       queue_push,
	output blsc_pkg::token_t           queue_tok
);
	import blsc_pkg::*;

	function automatic byte_class_t classify(input logic [7:0] c);
		byte_class_t r;
		case (c)
			CH_DQUOTE:  r = CLS_DQUOTE;
			CH_SQUOTE:  r = CLS_SQUOTE;
			CH_BQUOTE:  r = CLS_BQUOTE;
			CH_SLASH:   r = CLS_SLASH;
			CH_STAR:    r = CLS_STAR;
			CH_BSLASH:  r = CLS_BSLASH;
			CH_NEWLINE: r = CLS_NEWLINE;
			CH_LBRACE:  r = CLS_LBRACE;
			CH_LBRACK:  r = CLS_LBRACK;
			CH_RBRACE:  r = CLS_RBRACE;
			CH_RBRACK:  r = CLS_RBRACK;
			default:    r = CLS_OTHER;
		endcase
		return r;
	endfunction

	// take a byte whenever the queue has room
	assign text_ready = ~queue_full;
	assign queue_push = text_valid & ~queue_full;

	// classified token
	always_comb begin
		queue_tok.cls = classify(text_byte);
		queue_tok.eot = end_of_text;
	end

endmodule

`default_nettype wire

// ===== rtl/blsc_queue.sv =====
// ----------------------------------------------------------------------------
// blsc_queue: token queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module blsc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire blsc_pkg::token_t push_tok,
	output logic                  full,
	input  wire logic             pop,
	output blsc_pkg::token_t      head_tok,
	output logic                  empty
);
	import blsc_pkg::*;

	token_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_tok = slot_q[rd_ptr_q];

	// pointer wrap helper
	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QPTR_W'(1);
		end
		return r;
	endfunction

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/blsc_back.sv =====
// ----------------------------------------------------------------------------
// blsc_back: lexer and bracket stack
// Runs the lexer mode machine on tokens, keeps the closer stack, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blsc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire blsc_pkg::token_t tok,
	input  wire logic             tok_avail,
	output logic                  tok_take,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output logic [1:0]            scan_status,
	output logic [15:0]           literal_length
);
	import blsc_pkg::*;

	// state
	lex_mode_t               mode_q;
	logic [DEPTH_W-1:0]      depth_q;
	logic [POS_W-1:0]        pos_q;
	logic                    given_q;
	logic                    top_q;
	logic                    below_q;
	logic                    stack_mem [STACK_DEPTH];

	// output register
	logic                    res_valid_q;
	scan_status_t            res_status_q;
	logic [LEN_W-1:0]        res_length_q;

	// next-state signals
	lex_mode_t               mode_d;
	logic                    scan_code;
	logic                    at_limit;
	logic                    do_push;
	logic                    do_pop;
	logic                    push_bit;
	logic                    want_bit;
	logic                    st_valid;
	scan_status_t            st_code;
	logic                    res_valid;
	scan_status_t            res_status;
	logic [LEN_W-1:0]        res_length;
	logic [POS_W-1:0]        count;
	logic [DEPTH_W-1:0]      rd_depth;
	logic [STACK_IDX_W-1:0]  rd_idx;
	logic [STACK_IDX_W-1:0]  wr_idx;

	// a token is taken when the output register can hold a possible result
	assign tok_take = tok_avail & (~res_valid_q | result_ready);

	assign count    = pos_q + POS_W'(1);
	assign at_limit = (pos_q >= POS_W'(LEN_CAP));
	assign rd_depth = depth_q - DEPTH_W'(3);
	assign rd_idx   = rd_depth[STACK_IDX_W-1:0];
	assign wr_idx   = depth_q[STACK_IDX_W-1:0];

	// lexer mode machine and bracket decisions
	always_comb begin
		mode_d    = mode_q;
		scan_code = 1'b0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		push_bit  = 1'b0;
		want_bit  = 1'b0;
		st_valid  = 1'b0;
		st_code   = ST_BALANCED;
		if (!given_q) begin
			if (at_limit) begin
				st_valid = 1'b1;
				st_code  = ST_LIMIT;
			end else begin
				case (mode_q)
					MODE_CODE: begin
						scan_code = 1'b1;
					end
					MODE_SLASH: begin
						if (tok.cls == CLS_SLASH) begin
							mode_d = MODE_LINE;
						end else if (tok.cls == CLS_STAR) begin
							mode_d = MODE_BLOCK;
						end else begin
							mode_d    = MODE_CODE;
							scan_code = 1'b1;
						end
					end
					MODE_DQ: begin
						if (tok.cls == CLS_BSLASH) begin
							mode_d = MODE_DQ_ESC;
						end else if (tok.cls == CLS_DQUOTE) begin
							mode_d = MODE_CODE;
						end
					end
					MODE_SQ: begin
						if (tok.cls == CLS_BSLASH) begin
							mode_d = MODE_SQ_ESC;
						end else if (tok.cls == CLS_SQUOTE) begin
							mode_d = MODE_CODE;
						end
					end
					MODE_BQ: begin
						if (tok.cls == CLS_BSLASH) begin
							mode_d = MODE_BQ_ESC;
						end else if (tok.cls == CLS_BQUOTE) begin
							mode_d = MODE_CODE;
						end
					end
					MODE_DQ_ESC: mode_d = MODE_DQ;
					MODE_SQ_ESC: mode_d = MODE_SQ;
					MODE_BQ_ESC: mode_d = MODE_BQ;
					MODE_LINE: begin
						if (tok.cls == CLS_NEWLINE) begin
							mode_d = MODE_CODE;
						end
					end
					MODE_BLOCK: begin
						if (tok.cls == CLS_STAR) begin
							mode_d = MODE_BLOCK_STAR;
						end
					end
					MODE_BLOCK_STAR: begin
						if (tok.cls == CLS_SLASH) begin
							mode_d = MODE_CODE;
						end else if (tok.cls != CLS_STAR) begin
							mode_d = MODE_BLOCK;
						end
					end
					default: begin
						mode_d    = MODE_CODE;
						scan_code = 1'b1;
					end
				endcase

				// code byte: strings, comments and brackets
				if (scan_code) begin
					case (tok.cls)
						CLS_DQUOTE: mode_d = MODE_DQ;
						CLS_SQUOTE: mode_d = MODE_SQ;
						CLS_BQUOTE: mode_d = MODE_BQ;
						CLS_SLASH:  mode_d = MODE_SLASH;
						CLS_LBRACE, CLS_LBRACK: begin
							if (depth_q >= DEPTH_W'(STACK_DEPTH)) begin
								st_valid = 1'b1;
								st_code  = ST_LIMIT;
							end else begin
								do_push  = 1'b1;
								push_bit = (tok.cls == CLS_LBRACE);
							end
						end
						CLS_RBRACE, CLS_RBRACK: begin
							want_bit = (tok.cls == CLS_RBRACE);
							if (depth_q == '0 || top_q != want_bit) begin
								st_valid = 1'b1;
								st_code  = ST_MISMATCH;
							end else begin
								do_pop = 1'b1;
								if (depth_q == DEPTH_W'(1)) begin
									st_valid = 1'b1;
									st_code  = ST_BALANCED;
								end
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	// result selection: scan result first, otherwise open text at end
	always_comb begin
		res_valid  = 1'b0;
		res_status = ST_BALANCED;
		res_length = '0;
		if (st_valid) begin
			res_valid  = 1'b1;
			res_status = st_code;
			if (st_code == ST_BALANCED) begin
				res_length = LEN_W'(count);
			end
		end else if (tok.eot && !given_q) begin
			res_valid  = 1'b1;
			res_status = ST_OPEN;
		end
	end

	// scan state; end of text clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CODE;
			depth_q <= '0;
			pos_q   <= '0;
			given_q <= 1'b0;
		end else if (tok_take) begin
			if (tok.eot) begin
				mode_q  <= MODE_CODE;
				depth_q <= '0;
				pos_q   <= '0;
				given_q <= 1'b0;
			end else begin
				mode_q <= mode_d;
				if (!given_q && !at_limit) begin
					pos_q <= count;
				end
				if (st_valid) begin
					given_q <= 1'b1;
				end
				if (do_push) begin
					depth_q <= depth_q + DEPTH_W'(1);
				end else if (do_pop) begin
					depth_q <= depth_q - DEPTH_W'(1);
				end
			end
		end
	end

	// closer stack: top two entries in registers, the rest in memory
	always_ff @(posedge clk) begin
		if (tok_take && do_push) begin
			stack_mem[wr_idx] <= push_bit;
			top_q             <= push_bit;
			below_q           <= top_q;
		end else if (tok_take && do_pop) begin
			top_q   <= below_q;
			below_q <= stack_mem[rd_idx];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tok_take && res_valid) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take && res_valid) begin
			res_status_q <= res_status;
			res_length_q <= res_length;
		end
	end

	assign result_valid   = res_valid_q;
	assign scan_status    = res_status_q;
	assign literal_length = res_length_q;

endmodule

`default_nettype wire

// ===== sim/blsc_scan_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blsc_scan_checker: result checker for the balanced literal scanner
// Watches the byte and result channels, tracks the lexer mode and closer
// stack for each accepted byte, and compares every result transfer with
// the oldest predicted scan result.
// ----------------------------------------------------------------------------
module blsc_scan_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic        text_valid,
	input  logic        text_ready,
	input  logic [1:0]  scan_status,
	input  logic [15:0] literal_length,
	input  logic        result_valid,
	input  logic        result_ready,
	output int          error_count,
	output int          results_pending,
	output int          bytes_scanned
);
	import blsc_pkg::*;

	typedef struct {
		scan_status_t status;
		logic [15:0]  length;
	} scan_result_t;

	// predicted scan results, oldest first
	scan_result_t expected_results[$];
	scan_result_t oldest;

	// scan state of the current text
	lex_mode_t mode;
	bit        closer_is_brace[STACK_DEPTH];
	int        open_depth;
	int        text_position;
	bit        result_seen;

	function automatic void clear_scan();
		mode          = MODE_CODE;
		open_depth    = 0;
		text_position = 0;
		result_seen   = 1'b0;
	endfunction

	// a byte seen as code: quotes, slash and brackets
	function automatic bit scan_code(input logic [7:0] c, output scan_status_t st);
		st = ST_BALANCED;
		case (c)
			CH_DQUOTE: mode = MODE_DQ;
			CH_SQUOTE: mode = MODE_SQ;
			CH_BQUOTE: mode = MODE_BQ;
			CH_SLASH:  mode = MODE_SLASH;
			CH_LBRACE, CH_LBRACK: begin
				if (open_depth >= STACK_DEPTH) begin
					st = ST_LIMIT;
					return 1'b1;
				end
				closer_is_brace[open_depth] = (c == CH_LBRACE);
				open_depth++;
			end
			CH_RBRACE, CH_RBRACK: begin
				if (open_depth == 0 || closer_is_brace[open_depth - 1] != (c == CH_RBRACE)) begin
					st = ST_MISMATCH;
					return 1'b1;
				end
				open_depth--;
				if (open_depth == 0)
					return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// one byte through the lexer mode machine
	function automatic bit scan_byte(input logic [7:0] c, output scan_status_t st);
		st = ST_BALANCED;
		case (mode)
			MODE_SLASH: begin
				if (c == CH_SLASH)
					mode = MODE_LINE;
				else if (c == CH_STAR)
					mode = MODE_BLOCK;
				else begin
					mode = MODE_CODE;
					return scan_code(c, st);
				end
			end
			MODE_DQ, MODE_SQ, MODE_BQ: begin
				if (c == CH_BSLASH)
					mode = lex_mode_t'(mode + 1);
				else if ((mode == MODE_DQ && c == CH_DQUOTE) ||
					(mode == MODE_SQ && c == CH_SQUOTE) ||
					(mode == MODE_BQ && c == CH_BQUOTE))
					mode = MODE_CODE;
			end
			MODE_DQ_ESC, MODE_SQ_ESC, MODE_BQ_ESC: mode = lex_mode_t'(mode - 1);
			MODE_LINE: begin
				if (c == CH_NEWLINE)
					mode = MODE_CODE;
			end
			MODE_BLOCK: begin
				if (c == CH_STAR)
					mode = MODE_BLOCK_STAR;
			end
			MODE_BLOCK_STAR: begin
				if (c == CH_SLASH)
					mode = MODE_CODE;
				else if (c != CH_STAR)
					mode = MODE_BLOCK;
			end
			default: begin
				mode = MODE_CODE;
				return scan_code(c, st);
			end
		endcase
		return 1'b0;
	endfunction

	// predict the result, if any, caused by one accepted byte
	function automatic void predict_byte(input logic [7:0] c, input logic last);
		scan_status_t st;
		scan_result_t res;
		bit           hit;
		hit = 1'b0;
		st  = ST_BALANCED;
		if (!result_seen) begin
			bytes_scanned++;
			if (text_position + 1 > LEN_CAP) begin
				hit = 1'b1;
				st  = ST_LIMIT;
			end else begin
				text_position++;
				hit = scan_byte(c, st);
			end
			if (hit) begin
				res.status = st;
				res.length = (st == ST_BALANCED) ? 16'(text_position) : 16'd0;
				expected_results.insert(expected_results.size(), res);
				result_seen = 1'b1;
			end
		end
		// final byte closes the text
		if (last) begin
			if (!result_seen) begin
				res.status = ST_OPEN;
				res.length = 16'd0;
				expected_results.insert(expected_results.size(), res);
			end
			clear_scan();
		end
	endfunction

	// watch both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_results.delete();
			error_count     = 0;
			results_pending = 0;
			bytes_scanned   = 0;
		end else begin
			if (text_valid && text_ready)
				predict_byte(text_byte, end_of_text);
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: result with none expected: status %0d length %0d",
						$time, scan_status, literal_length);
				end else begin
					oldest = expected_results.pop_front();
					if (scan_status !== oldest.status) begin
						error_count++;
						$display("%0t: scan_status expected %0d actual %0d",
							$time, oldest.status, scan_status);
					end
					if (literal_length !== oldest.length) begin
						error_count++;
						$display("%0t: literal_length expected %0d actual %0d",
							$time, oldest.length, literal_length);
					end
				end
			end
			results_pending = expected_results.size();
		end
	end

endmodule

// ===== sim/balanced_literal_scanner_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// balanced_literal_scanner_unit_tb: testbench for the literal scanner
// Streams directed and random texts into the scanner with random gaps on
// both channels; the checker predicts and compares each scan result.
// ----------------------------------------------------------------------------
module balanced_literal_scanner_unit_tb;
	import blsc_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_BYTES = 1800;
	localparam int TAIL_CYCLES  = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic [7:0]  text_byte;
	logic        end_of_text;
	logic        text_valid;
	logic        text_ready;
	logic [1:0]  scan_status;
	logic [15:0] literal_length;
	logic        result_valid;
	logic        result_ready;

	int error_count;
	int results_pending;
	int bytes_scanned;
	int cycle_count = 0;
	int send_idle;
	int recv_idle;

	// bytes of the text being sent
	logic [7:0] text_buf[$];

	balanced_literal_scanner_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.scan_status(scan_status),
		.literal_length(literal_length),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	blsc_scan_checker scan_check (
		.clk(clk),
		.arst_n(arst_n),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.scan_status(scan_status),
		.literal_length(literal_length),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.error_count(error_count),
		.results_pending(results_pending),
		.bytes_scanned(bytes_scanned)
	);

	// clock
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side stalls
	always @(negedge clk) begin
		result_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
	end

	// append one byte to the text being built
	function automatic void append_byte(input logic [7:0] b);
		text_buf.insert(text_buf.size(), b);
	endfunction

	// random byte that is plain code: no bracket, quote, slash or star
	function automatic logic [7:0] code_filler();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_LBRACE || b == CH_LBRACK || b == CH_RBRACE || b == CH_RBRACK ||
			b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BQUOTE || b == CH_SLASH ||
			b == CH_STAR);
		return b;
	endfunction

	// one byte transfer, entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid  <= 1'b1;
		text_byte   <= b;
		end_of_text <= last;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic send_string(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
		send_text();
	endtask

	// append a string, a comment, a lone slash or plain code
	task automatic add_skipped();
		logic [7:0] q;
		logic [7:0] b;
		logic [7:0] prev;
		int         n;
		int         r;
		n = $urandom_range(0, 6);
		case ($urandom_range(0, 6))
			0: repeat (n + 1) append_byte(code_filler());
			1, 2, 3: begin
				r = $urandom_range(0, 2);
				q = (r == 0) ? CH_DQUOTE : ((r == 1) ? CH_SQUOTE : CH_BQUOTE);
				append_byte(q);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) begin
						append_byte(CH_BSLASH);
						append_byte(8'($urandom_range(0, 255)));
					end else begin
						do
							b = 8'($urandom_range(0, 255));
						while (b == q || b == CH_BSLASH);
						append_byte(b);
					end
				end
				append_byte(q);
			end
			4: begin
				// line comment
				append_byte(CH_SLASH);
				append_byte(CH_SLASH);
				repeat (n) begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == CH_NEWLINE);
					append_byte(b);
				end
				append_byte(CH_NEWLINE);
			end
			5: begin
				// block comment, sometimes opened as slash star slash
				append_byte(CH_SLASH);
				append_byte(CH_STAR);
				prev = 8'd0;
				if ($urandom_range(0, 2) == 0) begin
					append_byte(CH_SLASH);
					prev = CH_SLASH;
				end
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					if (prev == CH_STAR && b == CH_SLASH)
						b = CH_STAR;
					append_byte(b);
					prev = b;
				end
				repeat ($urandom_range(1, 2)) append_byte(CH_STAR);
				append_byte(CH_SLASH);
			end
			default: begin
				// lone slash
				append_byte(CH_SLASH);
				append_byte(code_filler());
			end
		endcase
	endtask

	// build one random text: mostly balanced literals, some broken or noise
	task automatic compose_text();
		bit want_brace[$];
		int shape;
		int steps;
		bit flip;
		bit closer;
		text_buf.delete();
		shape = $urandom_range(0, 99);
		if (shape < 8) begin
			repeat ($urandom_range(1, 24)) append_byte(8'($urandom_range(0, 255)));
			return;
		end
		// leading bytes before the opener
		if ($urandom_range(0, 4) == 0)
			add_skipped();
		if (shape < 12) begin
			// nesting around the stack depth
			repeat ($urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 2)) begin
				want_brace.insert(want_brace.size(), 1'($urandom_range(0, 1)));
				append_byte(want_brace[$] ? CH_LBRACE : CH_LBRACK);
			end
		end else begin
			want_brace.insert(want_brace.size(), 1'($urandom_range(0, 1)));
			append_byte(want_brace[$] ? CH_LBRACE : CH_LBRACK);
			steps = 0;
			while (want_brace.size() > 0 && steps < ((shape < 28) ? 6 : 24)) begin
				steps++;
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						if (want_brace.size() < 6) begin
							want_brace.insert(want_brace.size(), 1'($urandom_range(0, 1)));
							append_byte(want_brace[$] ? CH_LBRACE : CH_LBRACK);
						end
					end
					3, 4, 5: begin
						// wrong closer now and then in broken texts
						flip = (shape >= 12 && shape < 20 && $urandom_range(0, 3) == 0);
						closer = want_brace[$];
						want_brace.delete(want_brace.size() - 1);
						append_byte((closer ^ flip) ? CH_RBRACE : CH_RBRACK);
					end
					default: add_skipped();
				endcase
			end
		end
		if (shape >= 20 && shape < 28) begin
			// text ends open: inside a string, escape, comment or after a slash
			case ($urandom_range(0, 6))
				0: append_byte(CH_DQUOTE);
				1: begin
					append_byte(CH_SQUOTE);
					append_byte(CH_BSLASH);
				end
				2: append_byte(CH_BQUOTE);
				3: begin
					append_byte(CH_SLASH);
					append_byte(CH_SLASH);
				end
				4: begin
					append_byte(CH_SLASH);
					append_byte(CH_STAR);
					append_byte(CH_STAR);
				end
				5: append_byte(CH_SLASH);
				default: ;
			endcase
		end else begin
			while (want_brace.size() > 0) begin
				closer = want_brace[$];
				want_brace.delete(want_brace.size() - 1);
				append_byte(closer ? CH_RBRACE : CH_RBRACK);
			end
			// ignored bytes after the result
			repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random(input int count);
		int start;
		start = bytes_scanned;
		while (bytes_scanned - start < count) begin
			compose_text();
			send_text();
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n       = 1'b0;
		text_valid   = 1'b0;
		text_byte    = 8'd0;
		end_of_text  = 1'b0;
		result_ready = 1'b0;
		send_idle    = 36;
		recv_idle    = 81;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed texts
		send_string("[}");
		send_string("]");
		send_string("[/a]");
		send_string("{/*/}*/}");
		send_string("[\"\\\"]\"]");
		send_string("{}z");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// random texts under three idling patterns
		run_random(RANDOM_BYTES / 3);
		send_idle = 81;
		recv_idle = 36;
		run_random(RANDOM_BYTES / 3);
		send_idle = 0;
		recv_idle = 0;
		run_random(RANDOM_BYTES / 3);

		// drain
		text_valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0 && results_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/blsc_pkg.sv
rtl/blsc_front.sv
rtl/blsc_queue.sv
rtl/blsc_back.sv
rtl/balanced_literal_scanner_unit.sv
sim/blsc_scan_checker.sv
sim/balanced_literal_scanner_unit_tb.sv
